### sv/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and constants of the binary heap priority queue unit.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed widths of the item fields
  localparam int ROOT_W      = 32;
  localparam int COUNT_OUT_W = 11;

  localparam logic [ROOT_W-1:0] EMPTY_ANSWER = 32'd32767;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // register index taken from the word address
  localparam logic REG_MIN_MODE = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_UP_READ,
    OP_UP_EVAL,
    OP_DN_FETCH,
    OP_DN_LOAD,
    OP_DN_READ,
    OP_DN_EVAL,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    logic is_full;
    logic is_empty;
    logic at_root;
    logic up_more;
    logic dn_more;
  } dp_status_t;

endpackage

### sv/bhpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_datapath
// Heap memory, entry count, moving entry and result registers.
// ----------------------------------------------------------------------------
module bhpq_datapath #(
  parameter int CAPACITY   = bhpq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bhpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bhpq_pkg::dp_op_e                op_i,
  input  logic                            command_i,
  input  logic [bhpq_pkg::ROOT_W-1:0]     value_i,
  input  logic                            min_mode_i,
  output bhpq_pkg::dp_status_t            status_o,
  output logic [bhpq_pkg::ROOT_W-1:0]     root_value_o,
  output logic                            was_empty_o,
  output logic                            was_full_o,
  output logic [bhpq_pkg::COUNT_OUT_W-1:0] element_count_o
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [CW-1:0]         cnt_q;
  logic [AW-1:0]         pos_q;
  logic [DATA_WIDTH-1:0] cur_q;
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
  logic [ROOT_W-1:0]     res_root_q;
  logic                  res_empty_q, res_full_q;

  logic                  we;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] wdata;

  logic [DATA_WIDTH+ROOT_W-1:0] val_ext, root_ext;
  logic [CW+COUNT_OUT_W-1:0]    cnt_ext;
  logic [CW-1:0]                cnt_m1;
  logic [AW-1:0]                parent;
  logic [XW-1:0]                l_idx, r_idx, n_ext;
  logic                         l_ok, r_ok, up_more, dn_more;
  logic [DATA_WIDTH-1:0]        best1, best_val;
  logic [AW-1:0]                best_idx;

  function automatic logic ranks_above(input logic [DATA_WIDTH-1:0] a,
                                       input logic [DATA_WIDTH-1:0] b,
                                       input logic mm);
    if (mm) begin
      return $signed(a) < $signed(b);
    end
    return $signed(a) > $signed(b);
  endfunction

  assign val_ext  = {{DATA_WIDTH{value_i[ROOT_W-1]}}, value_i};
  assign root_ext = {{ROOT_W{rd_a_q[DATA_WIDTH-1]}}, rd_a_q};
  assign cnt_ext  = {{COUNT_OUT_W{1'b0}}, cnt_q};
  assign cnt_m1   = cnt_q - CW'(1);
  assign parent   = (pos_q - AW'(1)) >> 1;
  assign l_idx    = {1'b0, pos_q, 1'b1};
  assign r_idx    = {1'b0, pos_q, 1'b0} + XW'(2);
  assign n_ext    = XW'(cnt_q);

  // sift-up: the moving entry rises past a strictly worse parent
  assign up_more  = ranks_above(cur_q, rd_a_q, min_mode_i);

  // sift-down: pick the best of moving entry and both children
  assign l_ok     = (l_idx < n_ext) && ranks_above(rd_a_q, cur_q, min_mode_i);
  assign best1    = l_ok ? rd_a_q : cur_q;
  assign r_ok     = (r_idx < n_ext) && ranks_above(rd_b_q, best1, min_mode_i);
  assign best_val = r_ok ? rd_b_q : best1;
  assign best_idx = r_ok ? r_idx[AW-1:0] : l_idx[AW-1:0];
  assign dn_more  = l_ok || r_ok;

  assign status_o.is_full  = cnt_q >= CW'(CAPACITY);
  assign status_o.is_empty = cnt_q == '0;
  assign status_o.at_root  = pos_q == '0;
  assign status_o.up_more  = up_more;
  assign status_o.dn_more  = dn_more;

  always_comb begin
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = cur_q;
    raddr_a = parent;
    raddr_b = cnt_m1[AW-1:0];
    case (op_i)
      OP_UP_READ: begin
        we = status_o.at_root;
      end
      OP_UP_EVAL: begin
        we    = 1'b1;
        wdata = up_more ? rd_a_q : cur_q;
      end
      OP_DN_FETCH: begin
        raddr_a = '0;
      end
      OP_DN_READ: begin
        raddr_a = l_idx[AW-1:0];
        raddr_b = r_idx[AW-1:0];
      end
      OP_DN_EVAL: begin
        we    = 1'b1;
        wdata = dn_more ? best_val : cur_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (op_i)
        OP_START: begin
          if (command_i == CMD_INSERT && !status_o.is_full) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        OP_DN_LOAD: begin
          cnt_q <= cnt_m1;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_START: begin
        pos_q       <= cnt_q[AW-1:0];
        cur_q       <= val_ext[DATA_WIDTH-1:0];
        res_root_q  <= (command_i == CMD_EXTRACT && status_o.is_empty) ? EMPTY_ANSWER : '0;
        res_empty_q <= command_i == CMD_EXTRACT && status_o.is_empty;
        res_full_q  <= command_i == CMD_INSERT && status_o.is_full;
      end
      OP_UP_EVAL: begin
        if (up_more) begin
          pos_q <= parent;
        end
      end
      OP_DN_LOAD: begin
        res_root_q <= root_ext[ROOT_W-1:0];
        cur_q      <= rd_b_q;
        pos_q      <= '0;
      end
      OP_DN_EVAL: begin
        if (dn_more) begin
          pos_q <= best_idx;
        end
      end
      OP_LOAD_OUT: begin
        root_value_o    <= res_root_q;
        was_empty_o     <= res_empty_q;
        was_full_o      <= res_full_q;
        element_count_o <= cnt_ext[COUNT_OUT_W-1:0];
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

endmodule

### sv/bhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer of insert and extract commands and owner of the result valid.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bhpq_pkg::dp_status_t status_i,
  output bhpq_pkg::dp_op_e     op_o
);
  import bhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_EV,
    S_DN_FETCH,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_EV,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_free;

  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    case (state_q)
      S_IDLE:     op_o = in_valid_i ? OP_START : OP_NONE;
      S_UP_RD:    op_o = OP_UP_READ;
      S_UP_EV:    op_o = OP_UP_EVAL;
      S_DN_FETCH: op_o = OP_DN_FETCH;
      S_DN_LOAD:  op_o = OP_DN_LOAD;
      S_DN_RD:    op_o = OP_DN_READ;
      S_DN_EV:    op_o = OP_DN_EVAL;
      S_FIN:      op_o = out_free ? OP_LOAD_OUT : OP_NONE;
      default:    op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      // drop the result once taken, unless the next one replaces it now
      if (out_ready_i && state_q != S_FIN) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (command_i == CMD_INSERT) begin
              state_q <= status_i.is_full ? S_FIN : S_UP_RD;
            end else begin
              state_q <= status_i.is_empty ? S_FIN : S_DN_FETCH;
            end
          end
        end
        S_UP_RD: begin
          state_q <= status_i.at_root ? S_FIN : S_UP_EV;
        end
        S_UP_EV: begin
          state_q <= status_i.up_more ? S_UP_RD : S_FIN;
        end
        S_DN_FETCH: begin
          state_q <= S_DN_LOAD;
        end
        S_DN_LOAD: begin
          state_q <= S_DN_RD;
        end
        S_DN_RD: begin
          state_q <= S_DN_EV;
        end
        S_DN_EV: begin
          state_q <= status_i.dn_more ? S_DN_RD : S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/binary_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// Operation: one command at a time; each level of the sift loop is one memory read
//   followed by one compare and write.
// Reset: asynchronous, active low; clears the entry count, min_mode and the result valid.
//   The heap memory itself is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Array-backed min/max binary heap with insert and extract commands and an
// APB-style register for the order.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit #(
  parameter int CAPACITY   = bhpq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bhpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // command channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [bhpq_pkg::ROOT_W-1:0]      value_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bhpq_pkg::ROOT_W-1:0]      root_value_o,
  output logic                             was_empty_o,
  output logic                             was_full_o,
  output logic [bhpq_pkg::COUNT_OUT_W-1:0] element_count_o
);
  import bhpq_pkg::*;

  logic       min_mode_q;
  dp_status_t status;
  dp_op_e     op;

  // Register file: one word, min_mode in bit 0. The word index is paddr[2];
  // writes to the word past the list are dropped and read back as zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_MODE) ? {31'b0, min_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_MODE) begin
      min_mode_q <= pwdata[0];
    end
  end

  // Controller: walks insert (sift up) and extract (fetch root and last entry,
  // then sift down), then parks the result in the output register. A new
  // command is taken while that result still waits.
  bhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .op_o        (op)
  );

  // Datapath: heap memory with two registered read ports, the moving entry
  // kept in a register so each level costs one write instead of a swap.
  bhpq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .command_i       (command_i),
    .value_i         (value_i),
    .min_mode_i      (min_mode_q),
    .status_o        (status),
    .root_value_o    (root_value_o),
    .was_empty_o     (was_empty_o),
    .was_full_o      (was_full_o),
    .element_count_o (element_count_o)
  );

  // Show busy in the cycle after a command is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command taken while previous one still running");

  // An empty extract reports the fixed answer and an empty heap.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_empty_o |-> root_value_o == EMPTY_ANSWER && element_count_o == '0)
    else $error("empty extract result malformed");

  // A dropped insert leaves the heap at capacity.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_full_o |->
      element_count_o == COUNT_OUT_W'(CAPACITY) && !was_empty_o && root_value_o == '0)
    else $error("full insert result malformed");

  // A result waiting for the sink must not change under it.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_value_o)
      && $stable(element_count_o))
    else $error("stalled result changed");

endmodule

### tb/sv/tb_binary_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue_unit
// Drives insert and extract items into the heap in both orders. A shadow heap
// predicts each result, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue_unit;
  import bhpq_pkg::*;

  localparam int HEAP_DEPTH   = CAPACITY_DEF;
  // Receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES  = 300;
  // Slowest legal gap between two handshakes: an extract that sifts down the full depth,
  // plus the longest sender gap and receiver stall, with the long hold-off on top.
  // The limit leaves wide headroom above that.
  localparam int STUCK_LIMIT  = 2000;
  // Quiet time at the end, above the worst extract latency.
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] MIN_MODE_ADDR = {REG_MIN_MODE, 2'b00};

  typedef struct packed {
    logic [ROOT_W-1:0]      root;
    logic                   empty;
    logic                   full;
    logic [COUNT_OUT_W-1:0] count;
  } heap_result_t;

  // Drive every input to a known value from time zero.
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [2:0]             paddr       = '0;
  logic [31:0]            pwdata      = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic                   command_i   = CMD_INSERT;
  logic [ROOT_W-1:0]      value_i     = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [ROOT_W-1:0]      root_value_o;
  logic                   was_empty_o;
  logic                   was_full_o;
  logic [COUNT_OUT_W-1:0] element_count_o;

  // Shadow heap: the predicted contents, fill level and order.
  logic signed [31:0] shadow_heap [HEAP_DEPTH];
  int                 shadow_count     = 0;
  bit                 shadow_min_first = 1'b0;
  heap_result_t       expected_q [$];

  // Idling is on unless a test turns it off; hold_req asks for a long hold-off.
  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;

  int fail_count   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int drops_seen   = 0;
  int empties_seen = 0;
  int peak_fill    = 0;
  int stuck_cycles = 0;

  binary_heap_priority_queue_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .root_value_o    (root_value_o),
    .was_empty_o     (was_empty_o),
    .was_full_o      (was_full_o),
    .element_count_o (element_count_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Shadow heap
  // --------------------------------------------------------------------------

  // True when a belongs strictly above b in the current order. Ties never
  // rank above, so equal values stay where they are.
  function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
    return shadow_min_first ? (a < b) : (a > b);
  endfunction

  function automatic void shadow_swap(int x, int y);
    logic signed [31:0] t;
    t              = shadow_heap[x];
    shadow_heap[x] = shadow_heap[y];
    shadow_heap[y] = t;
  endfunction

  function automatic void shadow_sift_up(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!outranks(shadow_heap[pos], shadow_heap[up])) break;
      shadow_swap(pos, up);
      pos = up;
    end
  endfunction

  function automatic void shadow_sift_down(int pos);
    int best;
    int lc;
    int rc;
    while (pos < shadow_count) begin
      best = pos;
      lc   = 2 * pos + 1;
      rc   = 2 * pos + 2;
      // Compare the right child against the best so far, not the parent.
      if (lc < shadow_count && outranks(shadow_heap[lc], shadow_heap[best])) best = lc;
      if (rc < shadow_count && outranks(shadow_heap[rc], shadow_heap[best])) best = rc;
      if (best == pos) break;
      shadow_swap(pos, best);
      pos = best;
    end
  endfunction

  // Apply one command to the shadow heap and return the result it should give.
  function automatic heap_result_t heap_apply(logic cmd, logic [ROOT_W-1:0] val);
    heap_result_t r;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (shadow_count >= HEAP_DEPTH) begin
        r.full = 1'b1;
      end else begin
        shadow_heap[shadow_count] = val;
        shadow_count++;
        shadow_sift_up(shadow_count - 1);
      end
    end else if (shadow_count == 0) begin
      r.empty = 1'b1;
      r.root  = EMPTY_ANSWER;
    end else begin
      r.root         = shadow_heap[0];
      shadow_heap[0] = shadow_heap[shadow_count - 1];
      shadow_count--;
      shadow_sift_down(0);
    end
    r.count = COUNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    $display("%0t ns: mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
             $time, what, $signed(want), want, $signed(got), got);
  endtask

  // Predict at the edge where an item is taken, so the expectation is queued
  // well before its result can come out.
  always @(posedge clk_i) begin : command_tap
    heap_result_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r = heap_apply(command_i, value_i);
      expected_q = {expected_q, r};
      items_sent++;
      if (r.full) drops_seen++;
      if (r.empty) empties_seen++;
      if (shadow_count > peak_fill) peak_fill = shadow_count;
    end
  end

  // Pop the oldest expectation for each result taken and compare every field.
  always @(posedge clk_i) begin : result_check
    heap_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", '0, root_value_o);
      end else begin
        want = expected_q.pop_front();
        if (root_value_o !== want.root)
          report_mismatch("root_value", want.root, root_value_o);
        if (was_empty_o !== want.empty)
          report_mismatch("was_empty", 32'(want.empty), 32'(was_empty_o));
        if (was_full_o !== want.full)
          report_mismatch("was_full", 32'(want.full), 32'(was_full_o));
        if (element_count_o !== want.count)
          report_mismatch("element_count", 32'(want.count), 32'(element_count_o));
      end
    end
  end

  // Count cycles with no handshake on any port; give up past the limit.
  always @(posedge clk_i) begin : stuck_watch
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: %0d cycles without a handshake, %0d results still due",
                 STUCK_LIMIT, expected_q.size());
        $display("tb_binary_heap_priority_queue_unit failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts while idling is on, or one long hold-off
  // on request, counted here so the sender keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Offer one item and hold it until taken. Leave valid high on return so a
  // following item goes out back to back; drop it only for a gap or a pause.
  task automatic send_item(input logic cmd, input logic [ROOT_W-1:0] val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly full-range values, with the extremes and a narrow band near zero
  // so that ties come up often.
  function automatic logic [ROOT_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 8) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  // Random insert/extract mix. With quiet stretches, every third block of 40
  // items runs with no idling on either side.
  task automatic send_mix(input int n, input int insert_pct, input bit quiet_stretches);
    for (int k = 0; k < n; k++) begin
      if (quiet_stretches) idle_en = ((k / 40) % 3) != 2;
      if ($urandom_range(1, 100) <= insert_pct)
        send_item(CMD_INSERT, pick_value());
      else
        send_item(CMD_EXTRACT, $urandom());
    end
  endtask

  // Set the order over the register port while idle, then read it back.
  task automatic cfg_set_order(input bit min_first);
    wait_all_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_MODE_ADDR;
    pwdata  <= {31'b0, min_first};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    shadow_min_first = min_first;
    // Go straight into the read setup; keep psel high.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[0] !== min_first)
      report_mismatch("min_mode readback", 32'(min_first), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Largest first: extract from empty, the field extremes, zero, minus one
  // and a tie, then drain past empty.
  task automatic test_directed_max_order();
    cfg_set_order(1'b0);
    send_item(CMD_EXTRACT, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h7FFF_FFFF);
    send_item(CMD_INSERT, 32'h8000_0000);
    send_item(CMD_INSERT, 32'h0000_0000);
    send_item(CMD_INSERT, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'd5);
    send_item(CMD_INSERT, 32'd5);
    repeat (7) send_item(CMD_EXTRACT, 32'h0000_0000);
  endtask

  // Smallest first, with a tie and the most negative value.
  task automatic test_directed_min_order();
    cfg_set_order(1'b1);
    send_item(CMD_INSERT, 32'd3);
    send_item(CMD_INSERT, 32'hFFFF_FFF9);
    send_item(CMD_INSERT, 32'd3);
    send_item(CMD_INSERT, 32'h8000_0000);
    repeat (5) send_item(CMD_EXTRACT, 32'h5555_AAAA);
  endtask

  task automatic test_random_min_order();
    send_mix(60, 60, 1'b1);
  endtask

  // Flip the order with entries still held; the heap is not rebuilt.
  task automatic test_order_flip();
    cfg_set_order(1'b0);
    send_mix(40, 55, 1'b1);
  endtask

  // Hold the result side for a long stretch while items keep coming, then
  // pause the command side until everything is back.
  task automatic test_stall_and_pause();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    send_mix(12, 50, 1'b0);
    wait_all_results();
    idle_en = 1'b1;
    send_mix(6, 50, 1'b0);
  endtask

  // Fill to capacity, push a few dropped inserts, then drain partway.
  task automatic test_fill_to_capacity();
    int n;
    cfg_set_order(1'b1);
    idle_en = 1'b1;
    n = HEAP_DEPTH - shadow_count;
    repeat (n) send_item(CMD_INSERT, pick_value());
    repeat (4) send_item(CMD_INSERT, pick_value());
    send_mix(24, 20, 1'b0);
  endtask

  // Last part of the run: no idling on either side.
  task automatic test_quiet_tail();
    cfg_set_order(1'b0);
    idle_en = 1'b0;
    send_mix(40, 50, 1'b0);
  endtask

  initial begin : run
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_max_order();
    test_directed_min_order();
    test_random_min_order();
    test_order_flip();
    test_stall_and_pause();
    test_fill_to_capacity();
    test_quiet_tail();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items and %0d results in both orders, with %0d empty extracts",
             items_sent, results_seen, empties_seen);
    $display("heap peaked at %0d of %0d entries; %0d inserts dropped while full",
             peak_fill, HEAP_DEPTH, drops_seen);
    if (fail_count == 0) begin
      $display("tb_binary_heap_priority_queue_unit passed");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("tb_binary_heap_priority_queue_unit failed");
    end
    $finish;
  end

endmodule
